FILE: src/wait_queue_with_delete_defines.svh
// Assertion macros used by the wait queue sequencer.
`ifndef WAIT_QUEUE_WITH_DELETE_DEFINES_SVH
`define WAIT_QUEUE_WITH_DELETE_DEFINES_SVH

`ifndef SYNTHESIS

// A property that must hold at every rising clock edge outside reset.
`define WQD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wait queue check failed");

// A condition that must never be seen outside reset.
`define WQD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("wait queue forbidden condition seen");

`else

`define WQD_ASSERT(lbl, clk, rst_n, prop)
`define WQD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: src/wqd_pkg.sv
`default_nettype none

package wqd_pkg;

    // Queue geometry.
    localparam int DEPTH = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Field widths.
    localparam int ID_W     = 8;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef logic [PTR_W-1:0]    t_ptr;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [ID_W-1:0]     t_id;
    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [OCC_W-1:0]    t_occ;

    // Operation codes.
    localparam t_mode MODE_ADD      = 3'd0;
    localparam t_mode MODE_POP      = 3'd1;
    localparam t_mode MODE_REMOVE   = 3'd2;
    localparam t_mode MODE_UNBLOCK  = 3'd3;
    localparam t_mode MODE_WAKE_ALL = 3'd4;

    // Status codes.
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // One access to the slot store per cycle: a write and a read.
    typedef struct packed {
        logic we;
        t_ptr waddr;
        t_id  wdata;
        t_ptr raddr;
    } t_ram_req;

    // One result item.
    typedef struct packed {
        t_status status;
        t_id     value;
        logic    wake;
        logic    found;
        t_occ    occupancy;
        logic    last;
    } t_result;

endpackage

`default_nettype wire

FILE: src/wqd_ram.sv
`default_nettype none

module wqd_ram (
    input  logic              i_clk,
    input  wqd_pkg::t_ram_req i_req,
    output wqd_pkg::t_id      o_rd_data
);
    import wqd_pkg::*;

    t_id r_mem [DEPTH];
    t_id r_rd_data;

    // Single write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: src/wqd_seq.sv
`default_nettype none
`include "wait_queue_with_delete_defines.svh"

module wqd_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wqd_pkg::t_mode    i_mode,
    input  wqd_pkg::t_id      i_elem,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output wqd_pkg::t_result  o_res,
    output wqd_pkg::t_ram_req o_ram,
    input  wqd_pkg::t_id      i_rd_data
);
    import wqd_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // Circular address: base plus offset, folded back once past the end.
    function automatic t_ptr wrap_add(input t_ptr base, input t_cnt off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    logic [2:0] r_state, n_state;
    t_ptr       r_head,  n_head;
    t_cnt       r_held,  n_held;
    t_cnt       r_pos,   n_pos;
    t_mode      r_mode,  n_mode;
    t_id        r_elem,  n_elem;
    t_result    r_res,   n_res;

    t_cnt pos_next;
    logic match;

    // The compare unit used by the scan, and the position step shared by scan and shift.
    assign pos_next = r_pos + CNT_W'(1);
    assign match    = (i_rd_data == r_elem);

    assign o_in_ready = (r_state == S_IDLE);

    // Next state, store access and result.
    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_held  = r_held;
        n_pos   = r_pos;
        n_mode  = r_mode;
        n_elem  = r_elem;
        n_res   = r_res;

        o_ram.we    = 1'b0;
        o_ram.waddr = wrap_add(r_head, r_pos);
        o_ram.wdata = r_elem;
        o_ram.raddr = wrap_add(r_head, r_pos);

        o_res_valid = 1'b0;
        o_res       = r_res;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode = i_mode;
                    n_elem = i_elem;
                    n_res.status    = ST_OK;
                    n_res.value     = '0;
                    n_res.wake      = 1'b0;
                    n_res.found     = 1'b0;
                    n_res.occupancy = OCC_W'(r_held);
                    n_res.last      = 1'b1;
                    n_state         = S_EMIT;
                    case (i_mode)
                        MODE_ADD: begin
                            if (r_held == CNT_W'(DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_ram.we        = 1'b1;
                                o_ram.waddr     = wrap_add(r_head, r_held);
                                o_ram.wdata     = i_elem;
                                n_held          = r_held + CNT_W'(1);
                                n_res.occupancy = OCC_W'(r_held + CNT_W'(1));
                            end
                        end
                        MODE_POP, MODE_UNBLOCK: begin
                            if (r_held == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                o_ram.raddr = r_head;
                                n_state     = S_HEAD;
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_held == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                o_ram.raddr = r_head;
                                n_pos       = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        MODE_WAKE_ALL: begin
                            if (r_held == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_pos       = r_held - CNT_W'(1);
                                o_ram.raddr = wrap_add(r_head, r_held - CNT_W'(1));
                                n_state     = S_DRAIN;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            // Head entry is on the read port: take it out of the queue.
            S_HEAD: begin
                n_res.value     = i_rd_data;
                n_res.wake      = (r_mode == MODE_UNBLOCK);
                n_res.occupancy = OCC_W'(r_held - CNT_W'(1));
                n_held          = r_held - CNT_W'(1);
                n_head          = wrap_add(r_head, CNT_W'(1));
                n_state         = S_EMIT;
            end

            // Compare one entry a cycle from the head, prefetching the next.
            S_SCAN: begin
                o_ram.raddr = wrap_add(r_head, pos_next);
                if (match) begin
                    if (pos_next == r_held) begin
                        n_held          = r_held - CNT_W'(1);
                        n_res.found     = 1'b1;
                        n_res.occupancy = OCC_W'(r_held - CNT_W'(1));
                        n_state         = S_EMIT;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (pos_next == r_held) begin
                    n_state = S_EMIT;
                end else begin
                    n_pos = pos_next;
                end
            end

            // Move each entry behind the match one place towards the head.
            S_SHIFT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = wrap_add(r_head, r_pos);
                o_ram.wdata = i_rd_data;
                o_ram.raddr = wrap_add(r_head, r_pos + CNT_W'(2));
                n_pos       = pos_next;
                if (r_pos + CNT_W'(2) == r_held) begin
                    n_held          = r_held - CNT_W'(1);
                    n_res.found     = 1'b1;
                    n_res.occupancy = OCC_W'(r_held - CNT_W'(1));
                    n_state         = S_EMIT;
                end
            end

            // Stream every entry from the tail, one per transfer.
            S_DRAIN: begin
                o_res_valid     = 1'b1;
                o_res.status    = ST_OK;
                o_res.value     = i_rd_data;
                o_res.wake      = 1'b1;
                o_res.found     = 1'b0;
                o_res.occupancy = OCC_W'(r_pos);
                o_res.last      = (r_pos == '0);
                if (i_res_ready) begin
                    if (r_pos == '0) begin
                        n_held  = '0;
                        n_head  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_pos       = r_pos - CNT_W'(1);
                        o_ram.raddr = wrap_add(r_head, r_pos - CNT_W'(1));
                    end
                end
            end

            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_held  <= n_held;
        end
    end

    // Operation payload.
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_mode <= n_mode;
        r_elem <= n_elem;
        r_res  <= n_res;
    end

    `WQD_ASSERT(a_held_bound, i_clk, i_rst_n, r_held <= CNT_W'(DEPTH))
    `WQD_ASSERT(a_add_counts, i_clk, i_rst_n, (i_in_valid && o_in_ready && i_mode == MODE_ADD && r_held != CNT_W'(DEPTH)) |=> (r_held == $past(r_held) + CNT_W'(1)))
    `WQD_ASSERT(a_remove_no_grow, i_clk, i_rst_n, (r_state == S_SCAN || r_state == S_SHIFT) |=> (r_held <= $past(r_held)))
    `WQD_ASSERT_NEVER(a_walk_in_range, i_clk, i_rst_n, (r_state == S_SCAN || r_state == S_SHIFT || r_state == S_DRAIN) && !(r_pos < r_held))
    `WQD_ASSERT_NEVER(a_no_result_idle, i_clk, i_rst_n, o_res_valid && o_in_ready)

endmodule

`default_nettype wire

FILE: src/wait_queue_with_delete.sv
// Add, default modes: result via the emit state; pop and unblock via the head state first.
// Remove: one entry compared or moved per cycle by the scan unit.
// Unblock-all: from the tail, one result per cycle while not stalled, held results in all.
// A new item is taken once the last result of the previous one is in the output register.
// Synchronous active-low reset empties the queue and drops any pending result;
// slot contents are not cleared and need no clearing pass.
`default_nettype none

module wait_queue_with_delete (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  wqd_pkg::t_mode         i_mode,
    input  wqd_pkg::t_id           i_elem,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output wqd_pkg::t_status       o_status,
    output wqd_pkg::t_id           o_value,
    output logic                   o_wake,
    output logic                   o_found,
    output wqd_pkg::t_occ          o_occupancy,
    output logic                   o_last
);
    import wqd_pkg::*;

    t_ram_req ram_req;
    t_id      rd_data;
    logic     res_valid;
    logic     res_ready;
    t_result  res;
    t_result  r_out;
    logic     r_out_valid;

    wqd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_elem      (i_elem),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram       (ram_req),
        .i_rd_data   (rd_data)
    );

    wqd_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // Output register: loads whenever it is empty or its result is being transferred.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_value     = r_out.value;
    assign o_wake      = r_out.wake;
    assign o_found     = r_out.found;
    assign o_occupancy = r_out.occupancy;
    assign o_last      = r_out.last;

endmodule

`default_nettype wire

FILE: tb/wait_queue_with_delete_tb.sv
module wait_queue_with_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wqd_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 500000;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    // One line of the directed table: the operation and, where it is obvious, its result.
    typedef struct {
        t_mode   mode;
        t_id     elem;
        bit      given;
        t_result want;
    } t_drill;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    t_mode   i_mode = MODE_ADD;
    t_id     i_elem = '0;
    logic    i_out_ready = 1'b0;
    logic    o_in_ready;
    logic    o_out_valid;
    t_status o_status;
    t_id     o_value;
    logic    o_wake;
    logic    o_found;
    t_occ    o_occupancy;
    logic    o_last;

    // Predicted queue contents, head first, and the results still owed by the block.
    t_id     model_pids[$];
    t_result due_results[$];
    t_result fresh_results[$];
    t_drill  drill_rows[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int items_in = 0;
    int results_out = 0;
    int full_count = 0;
    int found_count = 0;
    int wake_count = 0;
    int longest_sweep = 0;
    int burst_left = 0;

    // Receiver state: its own stall pattern plus long hold-offs asked for by the sender side.
    int holds_asked = 0;
    int holds_taken = 0;
    int hold_left = 0;
    int sink_style = 0;
    int sink_left = 0;

    wait_queue_with_delete dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_elem      (i_elem),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_wake      (o_wake),
        .o_found     (o_found),
        .o_occupancy (o_occupancy),
        .o_last      (o_last)
    );

    always begin
        #HALF_PERIOD;
        i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0d] result %0d: %s", cycle_count, results_out, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
        end
    endtask

    function automatic t_result mk_result(input t_status st, input t_id v, input logic wk,
                                          input logic fd, input int occ, input logic lst);
        t_result r;
        r.status = st;
        r.value = v;
        r.wake = wk;
        r.found = fd;
        r.occupancy = t_occ'(occ);
        r.last = lst;
        return r;
    endfunction

    function automatic t_drill drill(input t_mode m, input t_id e, input bit given,
                                     input t_result want);
        t_drill d;
        d.mode = m;
        d.elem = e;
        d.given = given;
        d.want = want;
        return d;
    endfunction

    // Applies one operation to the predicted queue and lists the results it must give.
    task automatic predict_queue_op(input t_mode m, input t_id e);
        int hit;
        t_id head;
        fresh_results.delete();
        hit = -1;
        case (m)
            MODE_ADD: begin
                if (model_pids.size() >= DEPTH) begin
                    full_count++;
                    fresh_results.push_back(mk_result(ST_FULL, '0, 1'b0, 1'b0,
                                                      model_pids.size(), 1'b1));
                end else begin
                    model_pids.push_back(e);
                    fresh_results.push_back(mk_result(ST_OK, '0, 1'b0, 1'b0,
                                                      model_pids.size(), 1'b1));
                end
            end
            MODE_POP, MODE_UNBLOCK: begin
                if (model_pids.size() == 0) begin
                    fresh_results.push_back(mk_result(ST_EMPTY, '0, 1'b0, 1'b0, 0, 1'b1));
                end else begin
                    head = model_pids.pop_front();
                    if (m == MODE_UNBLOCK) begin
                        wake_count++;
                    end
                    fresh_results.push_back(mk_result(ST_OK, head, m == MODE_UNBLOCK, 1'b0,
                                                      model_pids.size(), 1'b1));
                end
            end
            MODE_REMOVE: begin
                if (model_pids.size() == 0) begin
                    fresh_results.push_back(mk_result(ST_EMPTY, '0, 1'b0, 1'b0, 0, 1'b1));
                end else begin
                    // Only the first match, counted from the head, goes.
                    for (int i = 0; i < model_pids.size() && hit < 0; i++) begin
                        if (model_pids[i] == e) begin
                            hit = i;
                        end
                    end
                    if (hit >= 0) begin
                        model_pids.delete(hit);
                        found_count++;
                    end
                    fresh_results.push_back(mk_result(ST_OK, '0, 1'b0, hit >= 0,
                                                      model_pids.size(), 1'b1));
                end
            end
            MODE_WAKE_ALL: begin
                if (model_pids.size() == 0) begin
                    fresh_results.push_back(mk_result(ST_EMPTY, '0, 1'b0, 1'b0, 0, 1'b1));
                end else begin
                    // Tail first; each result carries the count left in front of it.
                    for (int k = model_pids.size() - 1; k >= 0; k--) begin
                        fresh_results.push_back(mk_result(ST_OK, model_pids[k], 1'b1, 1'b0,
                                                          k, k == 0));
                    end
                    wake_count += model_pids.size();
                    if (model_pids.size() > longest_sweep) begin
                        longest_sweep = model_pids.size();
                    end
                    model_pids.delete();
                end
            end
            default: begin
                fresh_results.push_back(mk_result(ST_OK, '0, 1'b0, 1'b0,
                                                  model_pids.size(), 1'b1));
            end
        endcase
    endtask

    // Offers one operation and waits for its transfer. Unless steady, the sender works
    // in bursts, dropping valid for a random gap before the first item of each burst.
    task automatic offer(input t_mode m, input t_id e, input bit steady, input bit given,
                         input t_result want);
        int gap;
        gap = 0;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30)
                                                  : $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_elem <= e;
        do @(posedge i_clk); while (!o_in_ready);
        items_in++;
        predict_queue_op(m, e);
        if (given) begin
            due_results.push_back(want);
        end else begin
            foreach (fresh_results[i]) begin
                due_results.push_back(fresh_results[i]);
            end
        end
    endtask

    // Stops offering until every owed result has come back.
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (due_results.size() != 0);
    endtask

    function automatic t_mode pick_mode(input t_mix mix);
        int r;
        int add_cut;
        int rem_cut;
        int pop_cut;
        int unb_cut;
        int all_cut;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                add_cut = 62; rem_cut = 74; pop_cut = 83; unb_cut = 92; all_cut = 95;
            end
            MIX_DRAIN: begin
                add_cut = 25; rem_cut = 50; pop_cut = 68; unb_cut = 86; all_cut = 94;
            end
            default: begin
                add_cut = 42; rem_cut = 62; pop_cut = 75; unb_cut = 88; all_cut = 95;
            end
        endcase
        if (r < add_cut) return MODE_ADD;
        if (r < rem_cut) return MODE_REMOVE;
        if (r < pop_cut) return MODE_POP;
        if (r < unb_cut) return MODE_UNBLOCK;
        if (r < all_cut) return MODE_WAKE_ALL;
        return t_mode'($urandom_range(5, 7));
    endfunction

    // Removes mostly name an id that is held; adds often draw from a small pool so that
    // duplicates build up and the first-match rule gets exercised.
    function automatic t_id pick_elem(input t_mode m);
        if (m == MODE_REMOVE && model_pids.size() != 0 && $urandom_range(0, 9) < 7) begin
            return model_pids[$urandom_range(0, model_pids.size() - 1)];
        end
        if ($urandom_range(0, 1) == 1) begin
            return t_id'($urandom_range(0, 7));
        end
        return t_id'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(input t_mix mix, input int count);
        t_mode m;
        t_id e;
        repeat (count) begin
            m = pick_mode(mix);
            e = pick_elem(m);
            offer(m, e, 1'b0, 1'b0, '0);
        end
    endtask

    // Receiver: switches between its own stall styles, and honours long hold-offs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (holds_taken != holds_asked) begin
                holds_taken = holds_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (sink_left == 0) begin
                    sink_style = $urandom_range(0, 3);
                    sink_left = $urandom_range(16, 96);
                end else begin
                    sink_left--;
                end
                case (sink_style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 7) != 0);
                    default: i_out_ready <= ((sink_left % 5) >= 2);
                endcase
            end
        end
    end

    // Each result transfer is checked against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_out++;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("arrived with nothing owed (value %0d)", o_value));
            end else begin
                check_field("status", 8'(o_status), 8'(due_results[0].status));
                check_field("value", o_value, due_results[0].value);
                check_field("wake", 8'(o_wake), 8'(due_results[0].wake));
                check_field("found", 8'(o_found), 8'(due_results[0].found));
                check_field("occupancy", 8'(o_occupancy), 8'(due_results[0].occupancy));
                check_field("last", 8'(o_last), 8'(due_results[0].last));
                void'(due_results.pop_front());
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped at the cycle limit with %0d results owed",
                     due_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_mode m;
        t_id e;

        // Empty-queue cases straight after reset, and the no-operation modes.
        drill_rows.push_back(drill(MODE_POP, 8'h00, 1'b1,
                                   mk_result(ST_EMPTY, '0, 1'b0, 1'b0, 0, 1'b1)));
        drill_rows.push_back(drill(MODE_REMOVE, 8'hFF, 1'b1,
                                   mk_result(ST_EMPTY, '0, 1'b0, 1'b0, 0, 1'b1)));
        drill_rows.push_back(drill(MODE_UNBLOCK, 8'h5A, 1'b1,
                                   mk_result(ST_EMPTY, '0, 1'b0, 1'b0, 0, 1'b1)));
        drill_rows.push_back(drill(MODE_WAKE_ALL, 8'hA5, 1'b1,
                                   mk_result(ST_EMPTY, '0, 1'b0, 1'b0, 0, 1'b1)));
        drill_rows.push_back(drill(t_mode'(3'd7), 8'hAA, 1'b1,
                                   mk_result(ST_OK, '0, 1'b0, 1'b0, 0, 1'b1)));
        drill_rows.push_back(drill(t_mode'(3'd5), 8'h55, 1'b1,
                                   mk_result(ST_OK, '0, 1'b0, 1'b0, 0, 1'b1)));
        // Fill to the brim, with the extreme ids and a duplicate among them.
        drill_rows.push_back(drill(MODE_ADD, 8'h00, 1'b0, '0));
        drill_rows.push_back(drill(MODE_ADD, 8'hFF, 1'b0, '0));
        drill_rows.push_back(drill(MODE_ADD, 8'h10, 1'b0, '0));
        drill_rows.push_back(drill(MODE_ADD, 8'h80, 1'b0, '0));
        drill_rows.push_back(drill(MODE_ADD, 8'h7F, 1'b0, '0));
        drill_rows.push_back(drill(MODE_ADD, 8'h10, 1'b0, '0));
        for (int i = 0; i < DEPTH - 6; i++) begin
            drill_rows.push_back(drill(MODE_ADD, t_id'(8'h20 + i), 1'b0, '0));
        end
        drill_rows.push_back(drill(MODE_ADD, 8'h42, 1'b1,
                                   mk_result(ST_FULL, '0, 1'b0, 1'b0, DEPTH, 1'b1)));
        // Remove hits the first of the duplicates, then misses; then the head leaves twice.
        drill_rows.push_back(drill(MODE_REMOVE, 8'h10, 1'b0, '0));
        drill_rows.push_back(drill(MODE_REMOVE, 8'h99, 1'b0, '0));
        drill_rows.push_back(drill(MODE_POP, 8'h00, 1'b0, '0));
        drill_rows.push_back(drill(MODE_UNBLOCK, 8'h00, 1'b0, '0));
        drill_rows.push_back(drill(MODE_WAKE_ALL, 8'h00, 1'b0, '0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (drill_rows[i]) begin
            offer(drill_rows[i].mode, drill_rows[i].elem, 1'b0, drill_rows[i].given,
                  drill_rows[i].want);
        end
        pause_until_drained();

        random_phase(MIX_FILL, 80);

        // Long receiver hold-off while transfers keep coming, so the block backs up.
        holds_asked++;
        repeat (12) begin
            m = pick_mode(MIX_FILL);
            e = pick_elem(m);
            offer(m, e, 1'b1, 1'b0, '0);
        end
        pause_until_drained();

        random_phase(MIX_DRAIN, 60);
        random_phase(MIX_EVEN, 80);
        pause_until_drained();
        random_phase(MIX_FILL, 70);
        random_phase(MIX_EVEN, 60);
        random_phase(MIX_DRAIN, 30);

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d operations and %0d results: %0d full rejections, %0d remove hits",
                 items_in, results_out, full_count, found_count);
        $display("%0d wake requests, longest wake-all %0d, one long output hold-off",
                 wake_count, longest_sweep);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/wqd_pkg.sv
src/wqd_ram.sv
src/wqd_seq.sv
src/wait_queue_with_delete.sv
tb/wait_queue_with_delete_tb.sv
